/* src/median_threshold_binarizer_top_macros.svh */
// Assertion macros for the binarizer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef MEDIAN_THRESHOLD_BINARIZER_TOP_MACROS_SVH
`define MEDIAN_THRESHOLD_BINARIZER_TOP_MACROS_SVH

// Check a property on every clock outside reset
`define MTB_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define MTB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/mtb_pkg.sv */
// Shared types, codes and constants of the median threshold binarizer.
// No dependencies.
package mtb_pkg;

  localparam int MAX_PIXELS_DEF = 65536;

  // Grey weights and reciprocal of 100 (exact for sums below 25600)
  localparam int W_RED     = 30;
  localparam int W_GREEN   = 59;
  localparam int W_BLUE    = 11;
  localparam int SUM_W     = 15;
  localparam int RECIP_W   = 13;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] GREY_RECIP = 13'd5243;
  localparam int GREY_SHIFT = 19;

  localparam logic [7:0] PIX_WHITE = 8'd255;
  localparam logic [7:0] PIX_BLACK = 8'd0;
  localparam int HIST_BINS = 256;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] RES_THRESHOLD = 2'd0;
  localparam logic [1:0] RES_PIXEL     = 2'd1;
  localparam logic [1:0] RES_ERROR     = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] threshold;
    logic [7:0] pixel_out;
    logic       frame_end;
  } out_item_t;

  // Command passed from front to back
  typedef struct packed {
    logic       kind;
    logic [7:0] grey;
    logic       last;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_MED_RD,
    ST_MED_AC,
    ST_RD_RD,
    ST_EMIT
  } back_state_t;

endpackage

/* src/mtb_front.sv */
// Front: accepts input beats, forms the weighted grey sum, then scales to grey.
// Depends on mtb_pkg.
module mtb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mtb_pkg::in_item_t in_data,
  input  mtb_pkg::q_stat_t  q_stat,
  output logic              push,
  output mtb_pkg::cmd_t     push_cmd
);
  import mtb_pkg::*;

  logic             vld_r;
  logic             kind_r;
  logic             last_r;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [PROD_W-1:0] prod;
  logic             adv;

  // Weighted sum of the three channels
  assign sum_nxt = SUM_W'(in_data.red)   * SUM_W'(W_RED)
                 + SUM_W'(in_data.green) * SUM_W'(W_GREEN)
                 + SUM_W'(in_data.blue)  * SUM_W'(W_BLUE);

  assign adv      = !vld_r || !q_stat.full;
  assign in_stall = vld_r && q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_valid;
    end
    if (adv) begin
      kind_r <= in_data.kind;
      last_r <= in_data.last;
      sum_r  <= sum_nxt;
    end
  end

  // Divide by 100 through the reciprocal
  assign prod          = PROD_W'(sum_r) * PROD_W'(GREY_RECIP);
  assign push          = vld_r && !q_stat.full;
  assign push_cmd.kind = kind_r;
  assign push_cmd.last = last_r;
  assign push_cmd.grey = prod[GREY_SHIFT +: 8];
endmodule

/* src/mtb_queue.sv */
// Two-entry command queue between front and back.
// Depends on mtb_pkg.
module mtb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mtb_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output mtb_pkg::cmd_t    pop_cmd,
  output mtb_pkg::q_stat_t q_stat
);
  import mtb_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) ent_r[wp_r] <= push_cmd;
  end

  assign pop_cmd      = ent_r[rp_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
endmodule

/* src/mtb_back.sv */
// Back: histogram, frame store, median sweep, readout and result register.
// Depends on mtb_pkg and the assertion macro header.
`include "median_threshold_binarizer_top_macros.svh"
module mtb_back #(
  parameter int MAX_PIXELS = mtb_pkg::MAX_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mtb_pkg::q_stat_t   q_stat,
  input  mtb_pkg::cmd_t      pop_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mtb_pkg::out_item_t out_data
);
  import mtb_pkg::*;

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam logic [CW-1:0] CAP = CW'(MAX_PIXELS);

  back_state_t     state_r, state_nxt;
  logic [CW-1:0]   pc_r, pc_nxt;
  logic [CW-1:0]   rp_r, rp_nxt;
  logic [7:0]      med_r, med_nxt;
  logic            fr_r, fr_nxt;
  logic [7:0]      lvl_r, lvl_nxt;
  logic [CW-1:0]   run_r, run_nxt;
  logic [7:0]      grey_r, grey_nxt;
  logic            last_r, last_nxt;
  out_item_t       res_r, res_nxt;
  logic            out_vld_r;
  out_item_t       out_r;

  logic [CW-1:0]   hist_mem [HIST_BINS];
  logic [CW-1:0]   hist_q_r;
  logic [HIST_BINS-1:0] hist_vld_r;
  logic [7:0]      hist_raddr;
  logic            hist_we;
  logic            hist_clr;
  logic [CW-1:0]   hist_cnt;

  logic [7:0]      fs_mem [MAX_PIXELS];
  logic [7:0]      fs_q_r;
  logic            fs_we;
  logic [CW-1:0]   fs_waddr;

  logic            out_free;
  logic            out_load;
  logic [CW-1:0]   pc_eff;
  logic [CW-1:0]   run_sum;

  assign out_free = !out_vld_r || !out_stall;

  // Histogram memory: registered read, write of the incremented count
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[grey_r] <= hist_cnt + CW'(1);
    hist_q_r <= hist_mem[hist_raddr];
  end

  // Valid bits stand for the zero reset of every bin
  always_ff @(posedge clk) begin
    if (!rst_n || hist_clr) begin
      hist_vld_r <= '0;
    end else if (hist_we) begin
      hist_vld_r[grey_r] <= 1'b1;
    end
  end

  // Frame store: write on load, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr[AW-1:0]] <= pop_cmd.grey;
    fs_q_r <= fs_mem[rp_r[AW-1:0]];
  end

  assign hist_cnt = hist_vld_r[grey_r] ? hist_q_r : '0;
  assign run_sum  = run_r + (hist_vld_r[lvl_r] ? hist_q_r : '0);
  assign pc_eff   = fr_r ? '0 : pc_r;

  // Sequence one command at a time
  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    rp_nxt     = rp_r;
    med_nxt    = med_r;
    fr_nxt     = fr_r;
    lvl_nxt    = lvl_r;
    run_nxt    = run_r;
    grey_nxt   = grey_r;
    last_nxt   = last_r;
    res_nxt    = res_r;
    pop        = 1'b0;
    hist_raddr = pop_cmd.grey;
    hist_we    = 1'b0;
    hist_clr   = 1'b0;
    fs_we      = 1'b0;
    fs_waddr   = pc_eff;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          res_nxt = '{result_kind: RES_ERROR, threshold: 8'd0,
                      pixel_out: 8'd0, frame_end: 1'b0};
          if (pop_cmd.kind == KIND_LOAD) begin
            // Open a fresh frame after a finished one
            if (fr_r) begin
              hist_clr = 1'b1;
              fr_nxt   = 1'b0;
              rp_nxt   = '0;
              pc_nxt   = '0;
            end
            if (pc_eff == CAP) begin
              state_nxt = ST_EMIT;
            end else begin
              fs_we     = 1'b1;
              pc_nxt    = pc_eff + CW'(1);
              grey_nxt  = pop_cmd.grey;
              last_nxt  = pop_cmd.last;
              state_nxt = ST_LD_RD;
            end
          end else begin
            if (!fr_r || rp_r >= pc_r) begin
              state_nxt = ST_EMIT;
            end else begin
              state_nxt = ST_RD_RD;
            end
          end
        end
      end
      ST_LD_RD: begin
        hist_we = 1'b1;
        if (last_r) begin
          lvl_nxt   = 8'd0;
          run_nxt   = '0;
          state_nxt = ST_MED_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MED_RD: begin
        hist_raddr = lvl_r;
        state_nxt  = ST_MED_AC;
      end
      ST_MED_AC: begin
        run_nxt = run_sum;
        if (run_sum >= (pc_r >> 1) || lvl_r == 8'hFF) begin
          med_nxt   = lvl_r;
          fr_nxt    = 1'b1;
          rp_nxt    = '0;
          res_nxt   = '{result_kind: RES_THRESHOLD, threshold: lvl_r,
                        pixel_out: 8'd0, frame_end: 1'b0};
          state_nxt = ST_EMIT;
        end else begin
          lvl_nxt   = lvl_r + 8'd1;
          state_nxt = ST_MED_RD;
        end
      end
      ST_RD_RD: begin
        res_nxt = '{result_kind: RES_PIXEL, threshold: med_r,
                    pixel_out: (fs_q_r >= med_r) ? PIX_WHITE : PIX_BLACK,
                    frame_end: (rp_r + CW'(1) == pc_r)};
        rp_nxt    = rp_r + CW'(1);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pc_r      <= '0;
      rp_r      <= '0;
      med_r     <= 8'd0;
      fr_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      rp_r    <= rp_nxt;
      med_r   <= med_nxt;
      fr_r    <= fr_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
    lvl_r  <= lvl_nxt;
    run_r  <= run_nxt;
    grey_r <= grey_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
    if (out_load) out_r <= res_r;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `MTB_ASSERT_NEVER(a_rp_le_pc, rp_r > pc_r, "read pointer past pixel count")
  `MTB_ASSERT_PROP(a_ld_next, state_r == ST_LD_RD |=> state_r == ST_IDLE || state_r == ST_MED_RD, "bad state after load")
  `MTB_ASSERT_PROP(a_frame_rp, fr_r && !$past(fr_r) |-> rp_r == '0, "frame finished with nonzero read pointer")
endmodule

/* src/median_threshold_binarizer_top.sv */
// Top level of the median threshold binarizer: front, queue and back.
// Depends on mtb_pkg, mtb_front, mtb_queue and mtb_back.
//
//  channel | direction | handshake        | beat
//  in      | input     | in_valid/stall   | mtb_pkg::in_item_t
//  out     | output    | out_valid/stall  | mtb_pkg::out_item_t
//
// In the back a load goes through ST_LD_RD, a readout through ST_RD_RD and
// ST_EMIT, an error result through ST_EMIT. The last load adds a median sweep
// of ST_MED_RD and ST_MED_AC per grey level, up to 256 levels. A load after a
// finished frame clears the histogram at once. Reset is synchronous; the
// two-entry queue and the result register let either side stall on its own.
module median_threshold_binarizer_top #(
  parameter int MAX_PIXELS = mtb_pkg::MAX_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mtb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mtb_pkg::out_item_t out_data
);
  import mtb_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;

  mtb_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_stat, .push, .push_cmd
  );

  mtb_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .pop, .pop_cmd, .q_stat
  );

  mtb_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
    .clk, .rst_n, .q_stat, .pop_cmd, .pop,
    .out_valid, .out_stall, .out_data
  );
endmodule
